/* hdl/tml_pkg.sv */
// Shared types, constants and helper functions for the trimmed-mean level tracker.
package tml_pkg;

    localparam int ADC_W           = 12;
    localparam int LEVEL_W         = 12;
    localparam int DUTY_W          = 10;
    localparam int CNT_W           = 7;
    localparam int EVID_SUM_W      = CNT_W + 1;
    localparam int WEIGHT_W        = 6;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int STAGE_LEN       = 10;
    localparam int STAGE_CNT_W     = 4;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_OFFSET_RST  = 12'd2048;
    localparam logic [9:0]         DEADBAND_RST      = 10'd20;
    localparam logic [CNT_W-1:0]   TRIGGER_COUNT_RST = 7'd50;
    localparam logic [DUTY_W-1:0]  DUTY_CEILING_RST  = 10'd829;
    localparam logic [DUTY_W-1:0]  JUMP_START_RST    = 10'd810;
    localparam logic [DUTY_W-1:0]  JUMP_TARGET_RST   = 10'd830;

    localparam logic [LEVEL_W-1:0] GAP_LIM_5 = 12'd500;
    localparam logic [LEVEL_W-1:0] GAP_LIM_4 = 12'd400;
    localparam logic [LEVEL_W-1:0] GAP_LIM_3 = 12'd300;
    localparam logic [LEVEL_W-1:0] GAP_LIM_2 = 12'd200;
    localparam logic [LEVEL_W-1:0] GAP_LIM_1 = 12'd100;

    localparam logic [WEIGHT_W-1:0] WEIGHT_5 = 6'd50;
    localparam logic [WEIGHT_W-1:0] WEIGHT_4 = 6'd40;
    localparam logic [WEIGHT_W-1:0] WEIGHT_3 = 6'd30;
    localparam logic [WEIGHT_W-1:0] WEIGHT_2 = 6'd20;
    localparam logic [WEIGHT_W-1:0] WEIGHT_1 = 6'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_TRACK  = 2'd2
    } lamp_mode_t;

    typedef enum logic [2:0] {
        REG_LEVEL_OFFSET  = 3'd0,
        REG_DEADBAND      = 3'd1,
        REG_TRIGGER_COUNT = 3'd2,
        REG_DUTY_CEILING  = 3'd3,
        REG_JUMP_START    = 3'd4,
        REG_JUMP_TARGET   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_offset;
        logic [9:0]         deadband;
        logic [CNT_W-1:0]   trigger_count;
        logic [DUTY_W-1:0]  duty_ceiling;
        logic [DUTY_W-1:0]  jump_start;
        logic [DUTY_W-1:0]  jump_target;
    } tml_cfg_t;

    // Extra evidence added on top of the unit increment, growing with the gap.
    function automatic logic [WEIGHT_W-1:0] gap_weight(input logic [LEVEL_W-1:0] gap);
        logic [WEIGHT_W-1:0] w;
        if (gap > GAP_LIM_5)
            w = WEIGHT_5;
        else if (gap > GAP_LIM_4)
            w = WEIGHT_4;
        else if (gap > GAP_LIM_3)
            w = WEIGHT_3;
        else if (gap > GAP_LIM_2)
            w = WEIGHT_2;
        else if (gap > GAP_LIM_1)
            w = WEIGHT_1;
        else
            w = '0;
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(input logic [EVID_SUM_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v > EVID_SUM_W'(CNT_MAX))
            r = CNT_MAX;
        else
            r = v[CNT_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/tml_if.sv */
// Valid/ready channel interfaces for samples in and tracker results out.
interface tml_in_if;
    logic                       valid;
    logic                       ready;
    logic [tml_pkg::ADC_W-1:0]  adc_sample;
    logic                       tick;
    logic [1:0]                 lamp_mode;

    modport source (output valid, output adc_sample, output tick, output lamp_mode,
                    input ready);
    modport sink (input valid, input adc_sample, input tick, input lamp_mode,
                  output ready);
endinterface

interface tml_out_if;
    logic                         valid;
    logic                         ready;
    logic [tml_pkg::DUTY_W-1:0]   duty;
    logic [tml_pkg::LEVEL_W-1:0]  filtered_level;
    logic                         level_updated;

    modport source (output valid, output duty, output filtered_level,
                    output level_updated, input ready);
    modport sink (input valid, input duty, input filtered_level,
                  input level_updated, output ready);
endinterface

/* hdl/tml_apb_regs.sv */
// APB configuration register bank for the tracker.
module tml_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tml_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tml_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tml_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output tml_pkg::tml_cfg_t               cfg
);
    import tml_pkg::*;

    tml_cfg_t   cfg_reg;
    tml_cfg_t   cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LEVEL_OFFSET:  cfg_next.level_offset  = pwdata[LEVEL_W-1:0];
                REG_DEADBAND:      cfg_next.deadband      = pwdata[9:0];
                REG_TRIGGER_COUNT: cfg_next.trigger_count = pwdata[CNT_W-1:0];
                REG_DUTY_CEILING:  cfg_next.duty_ceiling  = pwdata[DUTY_W-1:0];
                REG_JUMP_START:    cfg_next.jump_start    = pwdata[DUTY_W-1:0];
                REG_JUMP_TARGET:   cfg_next.jump_target   = pwdata[DUTY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LEVEL_OFFSET:  prdata = APB_DATA_W'(cfg_reg.level_offset);
            REG_DEADBAND:      prdata = APB_DATA_W'(cfg_reg.deadband);
            REG_TRIGGER_COUNT: prdata = APB_DATA_W'(cfg_reg.trigger_count);
            REG_DUTY_CEILING:  prdata = APB_DATA_W'(cfg_reg.duty_ceiling);
            REG_JUMP_START:    prdata = APB_DATA_W'(cfg_reg.jump_start);
            REG_JUMP_TARGET:   prdata = APB_DATA_W'(cfg_reg.jump_target);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_offset  <= LEVEL_OFFSET_RST;
            cfg_reg.deadband      <= DEADBAND_RST;
            cfg_reg.trigger_count <= TRIGGER_COUNT_RST;
            cfg_reg.duty_ceiling  <= DUTY_CEILING_RST;
            cfg_reg.jump_start    <= JUMP_START_RST;
            cfg_reg.jump_target   <= JUMP_TARGET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/tml_trim_stage.sv */
// One trimmed-mean stage: gathers ten values, drops max and min, averages eight.
module tml_trim_stage #(
    parameter int SB = tml_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          feed,
    input  logic [SB-1:0] value,
    output logic          done,
    output logic [SB-1:0] mean
);
    import tml_pkg::*;

    localparam int SUM_W = SB + 4;

    logic [STAGE_CNT_W-1:0] cnt_reg;
    logic [STAGE_CNT_W-1:0] cnt_next;
    logic [SB-1:0]          max_reg;
    logic [SB-1:0]          max_next;
    logic [SB-1:0]          min_reg;
    logic [SB-1:0]          min_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       trimmed;

    // The minimum starts at all ones, so the first value always replaces it.
    assign max_next = (value >= max_reg) ? value : max_reg;
    assign min_next = (value <= min_reg) ? value : min_reg;
    assign sum_next = sum_reg + SUM_W'(value);
    assign cnt_next = cnt_reg + STAGE_CNT_W'(1);
    assign done     = (cnt_next >= STAGE_CNT_W'(STAGE_LEN));
    assign trimmed  = sum_next - SUM_W'(max_next) - SUM_W'(min_next);
    assign mean     = trimmed[SB+2:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            max_reg <= '0;
            min_reg <= '1;
            sum_reg <= '0;
        end
        else if (feed)
        begin
            if (done)
            begin
                cnt_reg <= '0;
                max_reg <= '0;
                min_reg <= '1;
                sum_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                max_reg <= max_next;
                min_reg <= min_next;
                sum_reg <= sum_next;
            end
        end
    end

endmodule

/* hdl/tml_tracker.sv */
// Duty tracker: tick bookkeeping, evidence counters and duty stepping.
module tml_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          tick,
    input  logic [1:0]                    mode,
    input  logic [tml_pkg::LEVEL_W-1:0]   level,
    input  tml_pkg::tml_cfg_t             cfg,
    output logic [tml_pkg::DUTY_W-1:0]    duty_next
);
    import tml_pkg::*;

    logic [DUTY_W-1:0]     duty_reg;
    logic [DUTY_W-1:0]     duty_n;
    logic [CNT_W-1:0]      up_reg;
    logic [CNT_W-1:0]      up_next;
    logic [CNT_W-1:0]      dn_reg;
    logic [CNT_W-1:0]      dn_next;
    logic                  pending_reg;
    logic                  pending_next;
    logic                  pend;
    logic                  track;
    logic [LEVEL_W-1:0]    diff;
    logic [LEVEL_W-2:0]    target;
    logic [LEVEL_W-1:0]    tgt_w;
    logic [LEVEL_W-1:0]    db_w;
    logic [LEVEL_W-1:0]    duty_w;
    logic                  go_up;
    logic                  go_dn;
    logic [EVID_SUM_W-1:0] up_sum;
    logic [EVID_SUM_W-1:0] dn_sum;

    assign diff   = level - cfg.level_offset;
    assign target = (level >= cfg.level_offset) ? diff[LEVEL_W-1:1] : '0;
    assign tgt_w  = LEVEL_W'(target);
    assign db_w   = LEVEL_W'(cfg.deadband);
    assign duty_w = LEVEL_W'(duty_reg);
    assign go_up  = tgt_w > (duty_w + db_w);
    assign go_dn  = duty_w > (tgt_w + db_w);
    assign up_sum = EVID_SUM_W'(up_reg) + EVID_SUM_W'(1)
                    + EVID_SUM_W'(gap_weight(tgt_w - duty_w));
    assign dn_sum = EVID_SUM_W'(dn_reg) + EVID_SUM_W'(1)
                    + EVID_SUM_W'(gap_weight(duty_w - tgt_w));

    assign pend      = pending_reg | tick;
    assign track     = (mode == MODE_TRACK) && pend;
    assign duty_next = duty_n;

    always_comb
    begin
        duty_n       = duty_reg;
        up_next      = up_reg;
        dn_next      = dn_reg;
        pending_next = pend;
        if (mode == MODE_OFF)
        begin
            duty_n = '0;
        end
        else if (track)
        begin
            pending_next = 1'b0;
            if (tgt_w < db_w)
            begin
                // A low target sets dn_reg to the trigger count, one short of a down step.
                dn_next = cfg.trigger_count;
            end
            else
            begin
                if (go_up)
                begin
                    up_next = sat_count(up_sum);
                    dn_next = '0;
                end
                else if (go_dn)
                begin
                    dn_next = sat_count(dn_sum);
                    up_next = '0;
                end
                else
                begin
                    up_next = '0;
                    dn_next = '0;
                end

                if ((up_next > cfg.trigger_count) || (dn_next > cfg.trigger_count))
                begin
                    if ((up_next > cfg.trigger_count) && (duty_reg < cfg.duty_ceiling))
                    begin
                        duty_n = duty_reg + DUTY_W'(1);
                        if (duty_n > cfg.jump_start)
                            duty_n = cfg.jump_target;
                    end
                    if ((dn_next > cfg.trigger_count) && (duty_n != '0))
                        duty_n = duty_n - DUTY_W'(1);
                    up_next = '0;
                    dn_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg    <= '0;
            up_reg      <= '0;
            dn_reg      <= '0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            duty_reg    <= duty_n;
            up_reg      <= up_next;
            dn_reg      <= dn_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* hdl/trimmed_mean_level_tracker.sv */
// Top level of the trimmed-mean level tracker: pipeline, filter stages and tracker.
// The tracker takes one sample per clock cycle while the output side does not
// stall and gives one result per sample. The first filter stage updates as the
// sample is taken, the second stage and the level register as it moves from the
// p1 to the p2 register, and the duty tracker as it moves from p2 into the output
// register. The whole pipeline moves only while the output register is empty or
// being taken, so a stalled result holds every later sample in place and the
// input ready drops only then. Configuration goes through the APB port and
// should only be written while no sample is in flight.
module trimmed_mean_level_tracker #(
    parameter int SAMPLE_BITS = tml_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tml_in_if.sink                          sample_in,
    tml_out_if.source                       result_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tml_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tml_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tml_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import tml_pkg::*;

    tml_cfg_t           cfg;
    logic               adv;
    logic               acc;

    logic               s1_done;
    logic [SAMPLE_BITS-1:0] s1_mean;
    logic               s2_feed;
    logic               s2_done;
    logic [SAMPLE_BITS-1:0] s2_mean;

    logic               p1_valid_reg;
    logic               p1_done_reg;
    logic [SAMPLE_BITS-1:0] p1_mid_reg;
    logic               p1_tick_reg;
    logic [1:0]         p1_mode_reg;

    logic               p2_valid_reg;
    logic               p2_updated_reg;
    logic               p2_tick_reg;
    logic [1:0]         p2_mode_reg;

    logic [SAMPLE_BITS-1:0] level_reg;

    logic               out_valid_reg;
    logic [DUTY_W-1:0]  out_duty_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_updated_reg;
    logic [DUTY_W-1:0]  duty_next;
    logic               trk_step;

    assign adv             = !out_valid_reg || result_out.ready;
    assign acc             = sample_in.valid && adv;
    assign sample_in.ready = adv;
    assign s2_feed         = adv && p1_valid_reg && p1_done_reg;
    assign trk_step        = adv && p2_valid_reg;

    assign result_out.valid          = out_valid_reg;
    assign result_out.duty           = out_duty_reg;
    assign result_out.filtered_level = out_level_reg;
    assign result_out.level_updated  = out_updated_reg;

    tml_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tml_trim_stage #(.SB(SAMPLE_BITS)) u_stage1 (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (acc),
        .value (sample_in.adc_sample[SAMPLE_BITS-1:0]),
        .done  (s1_done),
        .mean  (s1_mean)
    );

    tml_trim_stage #(.SB(SAMPLE_BITS)) u_stage2 (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (s2_feed),
        .value (p1_mid_reg),
        .done  (s2_done),
        .mean  (s2_mean)
    );

    // The tracker reads level_reg while its sample is in the second register;
    // a later sample can change the level only at that same edge.
    tml_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (trk_step),
        .tick      (p2_tick_reg),
        .mode      (p2_mode_reg),
        .level     (LEVEL_W'(level_reg)),
        .cfg       (cfg),
        .duty_next (duty_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                p1_valid_reg  <= acc;
                p2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= p2_valid_reg;
            end
            if (s2_feed && s2_done)
                level_reg <= s2_mean;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_done_reg     <= s1_done;
            p1_mid_reg      <= s1_mean;
            p1_tick_reg     <= sample_in.tick;
            p1_mode_reg     <= sample_in.lamp_mode;
            p2_updated_reg  <= p1_done_reg && s2_done;
            p2_tick_reg     <= p1_tick_reg;
            p2_mode_reg     <= p1_mode_reg;
            out_duty_reg    <= duty_next;
            out_level_reg   <= LEVEL_W'(level_reg);
            out_updated_reg <= p2_updated_reg;
        end
    end

endmodule

/* hdl/tml_checker.sv */
// Port-level checker for the tracker, bound to the top level.
module tml_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [tml_pkg::DUTY_W-1:0]  out_duty,
    input logic [tml_pkg::LEVEL_W-1:0] out_level,
    input logic out_updated
);
    logic out_xfer;

    assign out_xfer = out_valid && out_ready;

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_duty) && $stable(out_level)
                                    && $stable(out_updated))
        else $error("result payload changed while stalled");

    // The input side waits only while a finished result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // A level update needs a hundred samples, so two results in a row never both carry one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && out_updated |=> !(out_xfer && out_updated))
        else $error("level updates on consecutive results");

endmodule

bind trimmed_mean_level_tracker tml_checker u_tml_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sample_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_duty    (result_out.duty),
    .out_level   (result_out.filtered_level),
    .out_updated (result_out.level_updated)
);

/* tb/tb_trimmed_mean_level_tracker.sv */
// Self-checking testbench for the trimmed-mean level tracker: random sample streams and settings.
`timescale 1ns / 100ps

module tb_trimmed_mean_level_tracker;
    import tml_pkg::*;

    // The mode field can carry a code with no meaning; the block treats it as steady.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT = 7;

    typedef struct packed {
        logic [ADC_W-1:0] adc;
        logic             tick;
        logic [1:0]       mode;
    } sample_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [LEVEL_W-1:0] filtered_level;
        logic               level_updated;
    } tracker_result_t;

    typedef struct packed {
        logic [STAGE_CNT_W-1:0] cnt;
        logic [LEVEL_W-1:0]     hi;
        logic [15:0]            lo;
        logic [15:0]            acc;
    } trim_stage_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tml_in_if  sample_ch ();
    tml_out_if result_ch ();

    trimmed_mean_level_tracker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow of the tracker state and its settings.
    tml_cfg_t           tracker_cfg;
    trim_stage_t        stage_a;
    trim_stage_t        stage_b;
    logic [LEVEL_W-1:0] level_now;
    int                 duty_now;
    int                 up_evid;
    int                 down_evid;
    logic               tick_held;

    sample_item_t    sample_queue[$];
    tracker_result_t due_results[$];
    int n_issued;
    int n_accepted;
    int n_checked;
    int n_faults;
    logic quiet;

    // Neither side idles at random during one stretch in the middle of the run.
    assign quiet = (n_accepted >= 600) && (n_accepted < 900);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_fault(input string what);
        n_faults++;
        if (n_faults <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic logic trim_feed(inout trim_stage_t st, input logic [LEVEL_W-1:0] v,
                                       output logic [LEVEL_W-1:0] mean);
        logic [15:0] kept;
        logic        done;
        mean = '0;
        done = 1'b0;
        if (v >= st.hi)
            st.hi = v;
        if (16'(v) <= st.lo)
            st.lo = 16'(v);
        st.acc = st.acc + 16'(v);
        st.cnt = st.cnt + STAGE_CNT_W'(1);
        if (st.cnt >= STAGE_LEN)
        begin
            kept = st.acc - 16'(st.hi) - st.lo;
            mean = kept[14:3];
            st = '{cnt: '0, hi: '0, lo: 16'hFFFF, acc: '0};
            done = 1'b1;
        end
        return done;
    endfunction

    function automatic int evidence_weight(input int gap);
        if (gap > 500)
            return 50;
        if (gap > 400)
            return 40;
        if (gap > 300)
            return 30;
        if (gap > 200)
            return 20;
        if (gap > 100)
            return 10;
        return 0;
    endfunction

    function automatic tracker_result_t advance_tracker(input logic [ADC_W-1:0] adc,
                                                        input logic tick_in,
                                                        input logic [1:0] mode);
        tracker_result_t    r;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] fin;
        int                 target;
        int                 db;
        int                 trig;
        r.level_updated = 1'b0;
        db = int'(tracker_cfg.deadband);
        trig = int'(tracker_cfg.trigger_count);
        if (tick_in)
            tick_held = 1'b1;
        if (trim_feed(stage_a, adc, mid))
        begin
            if (trim_feed(stage_b, mid, fin))
            begin
                level_now = fin;
                r.level_updated = 1'b1;
            end
        end
        if (mode == MODE_OFF)
        begin
            duty_now = 0;
        end
        else if (mode == MODE_TRACK && tick_held)
        begin
            tick_held = 1'b0;
            target = 0;
            if (level_now >= tracker_cfg.level_offset)
                target = (int'(level_now) - int'(tracker_cfg.level_offset)) / 2;
            if (target < db)
            begin
                // A low target sets down_evid to the trigger count, one short of a down step.
                down_evid = trig;
            end
            else
            begin
                if (target > duty_now + db)
                begin
                    up_evid = up_evid + 1 + evidence_weight(target - duty_now);
                    if (up_evid > 127)
                        up_evid = 127;
                    down_evid = 0;
                end
                else if (duty_now > target + db)
                begin
                    down_evid = down_evid + 1 + evidence_weight(duty_now - target);
                    if (down_evid > 127)
                        down_evid = 127;
                    up_evid = 0;
                end
                else
                begin
                    up_evid = 0;
                    down_evid = 0;
                end
                if (up_evid > trig || down_evid > trig)
                begin
                    if (up_evid > trig && duty_now < int'(tracker_cfg.duty_ceiling))
                    begin
                        duty_now = duty_now + 1;
                        if (duty_now > int'(tracker_cfg.jump_start))
                            duty_now = int'(tracker_cfg.jump_target);
                    end
                    if (down_evid > trig && duty_now > 0)
                        duty_now = duty_now - 1;
                    up_evid = 0;
                    down_evid = 0;
                end
            end
        end
        r.duty = DUTY_W'(duty_now);
        r.filtered_level = level_now;
        return r;
    endfunction

    // Input side: prediction on every transfer, then the next item or an idle cycle.
    always @(posedge clk)
    begin : sample_driver
        sample_item_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                due_results.push_back(advance_tracker(sample_ch.adc_sample, sample_ch.tick,
                                                      sample_ch.lamp_mode));
                n_accepted++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = sample_queue.pop_front();
                    sample_ch.valid      <= 1'b1;
                    sample_ch.adc_sample <= nxt.adc;
                    sample_ch.tick       <= nxt.tick;
                    sample_ch.lamp_mode  <= nxt.mode;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        tracker_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    note_fault($sformatf("unexpected result duty=%0d level=%0d updated=%0b",
                                         result_ch.duty, result_ch.filtered_level,
                                         result_ch.level_updated));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.duty != result_ch.duty
                        || want.filtered_level != result_ch.filtered_level
                        || want.level_updated != result_ch.level_updated)
                        note_fault($sformatf({"result %0d: expected duty=%0d level=%0d ",
                                              "updated=%0b, got duty=%0d level=%0d updated=%0b"},
                                             n_checked, want.duty, want.filtered_level,
                                             want.level_updated, result_ch.duty,
                                             result_ch.filtered_level,
                                             result_ch.level_updated));
                    n_checked++;
                end
            end
            result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LEVEL_OFFSET:  tracker_cfg.level_offset = data[LEVEL_W-1:0];
            REG_DEADBAND:      tracker_cfg.deadband = data[9:0];
            REG_TRIGGER_COUNT: tracker_cfg.trigger_count = data[CNT_W-1:0];
            REG_DUTY_CEILING:  tracker_cfg.duty_ceiling = data[DUTY_W-1:0];
            REG_JUMP_START:    tracker_cfg.jump_start = data[DUTY_W-1:0];
            REG_JUMP_TARGET:   tracker_cfg.jump_target = data[DUTY_W-1:0];
            default:           ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_tracker(input int offset, input int db, input int trig,
                                   input int ceiling, input int jstart, input int jtarget);
        apb_write(REG_LEVEL_OFFSET, offset);
        apb_write(REG_DEADBAND, db);
        apb_write(REG_TRIGGER_COUNT, trig);
        apb_write(REG_DUTY_CEILING, ceiling);
        apb_write(REG_JUMP_START, jstart);
        apb_write(REG_JUMP_TARGET, jtarget);
    endtask

    task automatic queue_item(input logic [ADC_W-1:0] adc, input logic tick_in,
                              input logic [1:0] mode);
        sample_queue.push_back('{adc: adc, tick: tick_in, mode: mode});
        n_issued++;
    endtask

    // Samples settle around a level that moves now and then, with some outliers mixed in.
    task automatic queue_run(input int count, input int tick_pct, input int calm_pct);
        int         base;
        int         left;
        int         val;
        int         roll;
        int         k;
        logic [1:0] mode;
        base = 0;
        left = 0;
        for (k = 0; k < count; k++)
        begin
            if (left == 0)
            begin
                base = $urandom_range(4095);
                left = $urandom_range(140, 40);
            end
            left--;
            if ($urandom_range(99) < 8)
                val = $urandom_range(4095);
            else
                val = base + int'($urandom_range(64)) - 32;
            if (val < 0)
                val = 0;
            if (val > 4095)
                val = 4095;
            roll = $urandom_range(99);
            if (roll >= calm_pct)
                mode = MODE_TRACK;
            else if (roll % 3 == 0)
                mode = MODE_OFF;
            else if (roll % 3 == 1)
                mode = MODE_STEADY;
            else
                mode = MODE_SPARE;
            queue_item(ADC_W'(val), $urandom_range(99) < tick_pct, mode);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_checked != n_issued);
    endtask

    initial
    begin : stimulus
        int k;
        int offset;
        int db;
        int trig;
        int ceiling;
        int jstart;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.adc_sample = '0;
        sample_ch.tick = 1'b0;
        sample_ch.lamp_mode = MODE_OFF;
        result_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_issued = 0;
        n_accepted = 0;
        n_checked = 0;
        n_faults = 0;
        tracker_cfg = '{level_offset: LEVEL_OFFSET_RST, deadband: DEADBAND_RST,
                        trigger_count: TRIGGER_COUNT_RST, duty_ceiling: DUTY_CEILING_RST,
                        jump_start: JUMP_START_RST, jump_target: JUMP_TARGET_RST};
        stage_a = '{cnt: '0, hi: '0, lo: 16'hFFFF, acc: '0};
        stage_b = '{cnt: '0, hi: '0, lo: 16'hFFFF, acc: '0};
        level_now = '0;
        duty_now = 0;
        up_evid = 0;
        down_evid = 0;
        tick_held = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: ticks held over outside tracking mode,
        // the unused mode code, a low target, and a stage with both extremes to drop.
        queue_item(12'd0, 1'b0, MODE_OFF);
        queue_item(12'd4095, 1'b1, MODE_STEADY);
        queue_item(12'd4095, 1'b1, MODE_SPARE);
        queue_item(12'd0, 1'b0, MODE_TRACK);
        queue_item(12'd2048, 1'b1, MODE_TRACK);
        queue_item(12'd4095, 1'b0, MODE_TRACK);
        queue_item(12'd1, 1'b1, MODE_OFF);
        queue_item(12'd4094, 1'b0, MODE_TRACK);
        queue_item(12'hAAA, 1'b1, MODE_SPARE);
        queue_item(12'h555, 1'b0, MODE_TRACK);
        for (k = 0; k < 10; k++)
            queue_item((k == 3) ? 12'd4095 : (k == 6) ? 12'd0 : ADC_W'(1000 + 37 * k),
                       1'b1, MODE_TRACK);
        wait_drained();

        // Fast stepping with a low ceiling, so the jump and the ceiling are both reached.
        program_tracker(0, 2, 0, 60, 40, 100);
        queue_run(300, 90, 3);
        wait_drained();

        program_tracker(4095, 1023, 127, 1023, 1023, 1023);
        queue_run(120, 60, 15);
        wait_drained();

        program_tracker(0, 0, 0, 0, 0, 0);
        queue_run(150, 70, 10);
        wait_drained();

        for (k = 0; k < 4; k++)
        begin
            offset = $urandom_range(2048);
            db = ($urandom_range(99) < 20) ? $urandom_range(1023) : $urandom_range(40);
            trig = ($urandom_range(99) < 25) ? $urandom_range(127) : $urandom_range(12);
            ceiling = ($urandom_range(99) < 30) ? $urandom_range(1023) : $urandom_range(150);
            jstart = $urandom_range(ceiling);
            program_tracker(offset, db, trig, ceiling, jstart, $urandom_range(1023));
            queue_run(180, $urandom_range(100, 20), 8);
            wait_drained();
        end

        program_tracker(int'(LEVEL_OFFSET_RST), int'(DEADBAND_RST), int'(TRIGGER_COUNT_RST),
                        int'(DUTY_CEILING_RST), int'(JUMP_START_RST), int'(JUMP_TARGET_RST));
        queue_run(160, 50, 10);
        wait_drained();

        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
            note_fault($sformatf("%0d results never arrived", due_results.size()));
        if (n_faults == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
hdl/tml_pkg.sv
hdl/tml_if.sv
hdl/tml_apb_regs.sv
hdl/tml_trim_stage.sv
hdl/tml_tracker.sv
hdl/trimmed_mean_level_tracker.sv
hdl/tml_checker.sv
tb/tb_trimmed_mean_level_tracker.sv
